// ===== design/crc8fc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8fc_pkg - shared types and constants of the CRC-8 frame checker
// Frame layout constants, reply descriptor and configuration types, and the
// bytewise CRC-8 update used by the frame parser.
// ----------------------------------------------------------------------------
package crc8fc_pkg;

   localparam int SHORT_PAYLOAD = 5;
   localparam int LONG_PAYLOAD  = 6;

   // position of the CRC byte; the end byte follows it
   localparam logic [3:0] SHORT_CRC_POS = 4'(4 + SHORT_PAYLOAD);
   localparam logic [3:0] LONG_CRC_POS  = 4'(4 + LONG_PAYLOAD);

   // expected size byte: frame length minus 3
   localparam logic [7:0] SHORT_SIZE = 8'(SHORT_PAYLOAD + 3);
   localparam logic [7:0] LONG_SIZE  = 8'(LONG_PAYLOAD + 3);

   localparam logic [7:0] CRC_POLY_RESET     = 8'h28;
   localparam logic [7:0] START_MARKER_RESET = 8'hFE;
   localparam logic [7:0] END_MARKER_RESET   = 8'hFF;
   localparam logic [7:0] LONG_ID_A_RESET    = 8'hB1;
   localparam logic [7:0] LONG_ID_B_RESET    = 8'hB2;

   localparam logic [7:0] REPLY_CODE = 8'h02;
   localparam logic [7:0] ACK_CODE   = 8'h01;
   localparam logic [7:0] NACK_CODE  = 8'h00;

   localparam int REPLY_LEN = 5;
   localparam int BEAT_W    = $clog2(REPLY_LEN);
   localparam logic [BEAT_W-1:0] BEAT_START = BEAT_W'(0);
   localparam logic [BEAT_W-1:0] BEAT_CODE  = BEAT_W'(1);
   localparam logic [BEAT_W-1:0] BEAT_ID    = BEAT_W'(2);
   localparam logic [BEAT_W-1:0] BEAT_ACK   = BEAT_W'(3);
   localparam logic [BEAT_W-1:0] BEAT_END   = BEAT_W'(REPLY_LEN - 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register indexes on the configuration port
   localparam logic [2:0] REG_CRC_POLY     = 3'd0;
   localparam logic [2:0] REG_START_MARKER = 3'd1;
   localparam logic [2:0] REG_END_MARKER   = 3'd2;
   localparam logic [2:0] REG_LONG_ID_A    = 3'd3;
   localparam logic [2:0] REG_LONG_ID_B    = 3'd4;

   typedef struct packed {
      logic [7:0] crc_poly;
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic [7:0] long_id_a;
      logic [7:0] long_id_b;
   } cfg_type;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic [7:0] frame_id;
      logic       ack;
   } reply_desc_type;

   // MSB-first CRC-8 over one byte, x^8 implied in poly
   function automatic logic [7:0] crc8_step(input logic [7:0] crc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== design/crc8fc_front.sv =====
// ----------------------------------------------------------------------------
// crc8fc_front - frame parser
// Tracks the byte position, runs the payload CRC and the frame checks, and
// pushes one reply descriptor into the queue on each end byte.
// ----------------------------------------------------------------------------
module crc8fc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  crc8fc_pkg::cfg_type      cfg,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,
   input  logic                     q_full,
   output logic                     q_push,
   output crc8fc_pkg::reply_desc_type q_desc
);
   import crc8fc_pkg::*;

   logic [3:0] pos_ff, pos_in;
   logic       long_ff, long_in;
   logic [7:0] id_ff, id_in;
   logic [7:0] size_ff, size_in;
   logic [7:0] crc_ff, crc_in;
   logic       start_good_ff, start_good_in;
   logic       crc_good_ff, crc_good_in;

   logic [3:0] crc_pos;
   logic [7:0] exp_size;
   logic       at_end;
   logic       accept;

   assign crc_pos  = long_ff ? LONG_CRC_POS : SHORT_CRC_POS;
   assign exp_size = long_ff ? LONG_SIZE : SHORT_SIZE;
   assign at_end   = pos_ff > crc_pos;

   // stall only on an end byte with no room for its reply
   assign req_tready = !(at_end && q_full);
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && at_end;

   assign q_desc.start_marker = cfg.start_marker;
   assign q_desc.end_marker   = cfg.end_marker;
   assign q_desc.frame_id     = id_ff;
   assign q_desc.ack          = start_good_ff && crc_good_ff &&
                                (req_tdata == cfg.end_marker) && (size_ff == exp_size);

   always_comb begin
      pos_in        = pos_ff;
      long_in       = long_ff;
      id_in         = id_ff;
      size_in       = size_ff;
      crc_in        = crc_ff;
      start_good_in = start_good_ff;
      crc_good_in   = crc_good_ff;
      if (accept) begin
         pos_in = pos_ff + 4'd1;
         priority if (pos_ff == 4'd0) begin
            start_good_in = (req_tdata == cfg.start_marker);
            crc_in        = 8'h00;
            crc_good_in   = 1'b0;
         end else if (pos_ff == 4'd1) begin
            size_in = req_tdata;
         end else if (pos_ff == 4'd2) begin
            id_in   = req_tdata;
            long_in = (req_tdata == cfg.long_id_a) || (req_tdata == cfg.long_id_b);
         end else if (pos_ff == 4'd3) begin
            // unchecked byte: skip
         end else if (pos_ff < crc_pos) begin
            crc_in = crc8_step(crc_ff, req_tdata, cfg.crc_poly);
         end else if (pos_ff == crc_pos) begin
            crc_good_in = (req_tdata == crc_ff);
         end else begin
            pos_in = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 4'd0;
         long_ff       <= 1'b0;
         id_ff         <= 8'h00;
         size_ff       <= 8'h00;
         crc_ff        <= 8'h00;
         start_good_ff <= 1'b0;
         crc_good_ff   <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         long_ff       <= long_in;
         id_ff         <= id_in;
         size_ff       <= size_in;
         crc_ff        <= crc_in;
         start_good_ff <= start_good_in;
         crc_good_ff   <= crc_good_in;
      end
   end

endmodule

// ===== design/crc8fc_queue.sv =====
// ----------------------------------------------------------------------------
// crc8fc_queue - reply descriptor queue
// Short first-in first-out store between the frame parser and the reply
// sender.
// ----------------------------------------------------------------------------
module crc8fc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  crc8fc_pkg::reply_desc_type push_desc,
   output logic                       full,
   input  logic                       pop,
   output logic                       empty,
   output crc8fc_pkg::reply_desc_type head_desc
);
   import crc8fc_pkg::*;

   reply_desc_type           store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        count_ff, count_in;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign head_desc = store_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("reply queue pushed while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("reply queue popped while empty");

endmodule

// ===== design/crc8fc_back.sv =====
// ----------------------------------------------------------------------------
// crc8fc_back - reply sender
// Expands the queue head into five reply bytes through a registered output.
// ----------------------------------------------------------------------------
module crc8fc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  crc8fc_pkg::reply_desc_type q_desc,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);
   import crc8fc_pkg::*;

   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic              valid_ff, valid_in;
   logic [7:0]        data_ff, data_in;
   logic              ack_ff, ack_in;
   logic              last_ff, last_in;
   logic              load;
   logic [7:0]        beat_byte;

   assign load  = !valid_ff || rsp_tready;
   assign q_pop = load && !q_empty && (beat_ff == BEAT_END);

   always_comb begin
      unique case (beat_ff)
         BEAT_START: beat_byte = q_desc.start_marker;
         BEAT_CODE:  beat_byte = REPLY_CODE;
         BEAT_ID:    beat_byte = q_desc.frame_id;
         BEAT_ACK:   beat_byte = q_desc.ack ? ACK_CODE : NACK_CODE;
         BEAT_END:   beat_byte = q_desc.end_marker;
         default:    beat_byte = q_desc.end_marker;
      endcase
   end

   always_comb begin
      beat_in  = beat_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      ack_in   = ack_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            data_in = beat_byte;
            ack_in  = q_desc.ack;
            last_in = beat_ff == BEAT_END;
            beat_in = (beat_ff == BEAT_END) ? BEAT_START : beat_ff + BEAT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      ack_ff  <= ack_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= BEAT_START;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = ack_ff;
   assign rsp_tlast  = last_ff;

   a_beat_range: assert property (@(posedge clock) disable iff (reset)
      beat_ff <= BEAT_END)
      else $error("reply beat counter out of range");

   a_last_starts_over: assert property (@(posedge clock) disable iff (reset)
      (load && !q_empty && beat_ff == BEAT_END) |=> (beat_ff == BEAT_START && rsp_tlast))
      else $error("reply end byte not followed by a fresh reply");

endmodule

// ===== design/crc8_frame_checker_ack.sv =====
// ----------------------------------------------------------------------------
// crc8_frame_checker_ack - CRC-8 frame checker with ACK/NACK reply
// Parses received frames, checks start, size, payload CRC and end, and sends
// a five-byte acknowledge or reject reply for each frame.
// ----------------------------------------------------------------------------
// Received bytes enter on the req_ stream at one byte per clock while
// req_tready is high: the frame parser updates the payload CRC with an
// unrolled 8-bit step. A frame is start, size, id, one unchecked byte,
// a five-byte payload (six when the id matches long_id_a or long_id_b), a
// CRC byte and an end byte. On the end byte the parser pushes a reply
// descriptor into a two-entry queue; the reply sender turns each descriptor
// into five rsp_ bytes (start_marker, 0x02, id, 0x01 ACK or 0x00 NACK,
// end_marker) at one byte per clock while rsp_tready is high, through an
// output register: the queue stores the descriptor taken with the end byte,
// and the sender loads each reply byte from it into that register. rsp_tuser
// carries the ACK flag on every reply byte and rsp_tlast marks the fifth.
// The input stalls only when an end byte arrives and the queue already holds
// two replies; since a frame is at least eleven bytes and a reply five, a
// free-flowing output never stalls the input. A bad start byte does not
// resynchronise: the frame is still counted in full and answered with NACK.
// Registers sit at byte addresses 0 (crc_poly), 4 (start_marker),
// 8 (end_marker), 12 (long_id_a) and 16 (long_id_b); write them only while
// no frame is in progress and no reply is pending.
// ----------------------------------------------------------------------------
module crc8_frame_checker_ack (
   input  logic        clock,
   input  logic        reset,
   // received byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   // reply byte stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] tx_byte
   output logic        rsp_tuser,    // [0] is_ack
   output logic        rsp_tlast,    // last_byte
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import crc8fc_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   logic           csr_write;
   logic [2:0]     csr_index;
   logic [7:0]     rd_byte;

   logic           q_push, q_pop, q_full, q_empty;
   reply_desc_type push_desc, head_desc;

   // registers: decode the word index, drop writes beyond the list
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_CRC_POLY:     cfg_in.crc_poly     = csr_pwdata[7:0];
            REG_START_MARKER: cfg_in.start_marker = csr_pwdata[7:0];
            REG_END_MARKER:   cfg_in.end_marker   = csr_pwdata[7:0];
            REG_LONG_ID_A:    cfg_in.long_id_a    = csr_pwdata[7:0];
            REG_LONG_ID_B:    cfg_in.long_id_b    = csr_pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CRC_POLY:     rd_byte = cfg_ff.crc_poly;
         REG_START_MARKER: rd_byte = cfg_ff.start_marker;
         REG_END_MARKER:   rd_byte = cfg_ff.end_marker;
         REG_LONG_ID_A:    rd_byte = cfg_ff.long_id_a;
         REG_LONG_ID_B:    rd_byte = cfg_ff.long_id_b;
         default:          rd_byte = 8'h00;
      endcase
   end

   assign csr_prdata = {24'h000000, rd_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_poly     <= CRC_POLY_RESET;
         cfg_ff.start_marker <= START_MARKER_RESET;
         cfg_ff.end_marker   <= END_MARKER_RESET;
         cfg_ff.long_id_a    <= LONG_ID_A_RESET;
         cfg_ff.long_id_b    <= LONG_ID_B_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // parse frames and classify them
   crc8fc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_desc     (push_desc)
   );

   // hold pending replies
   crc8fc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_desc (head_desc)
   );

   // send each reply byte by byte
   crc8fc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_desc     (head_desc),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_cfg_stable: assert property (@(posedge clock) disable iff (reset)
      !csr_write |=> (cfg_ff == $past(cfg_ff)))
      else $error("configuration changed without a register write");

endmodule
